>>> hw/rtl/srde_pkg.sv
package srde_pkg;

  // Radix codes as they appear on the radix_kind output.
  localparam logic [1:0] KIND_BIN = 2'd0;
  localparam logic [1:0] KIND_OCT = 2'd1;
  localparam logic [1:0] KIND_HEX = 2'd2;
  localparam logic [1:0] KIND_BCD = 2'd3;

  // Mode codes on the func input.
  localparam logic [2:0] FUNC_ALL = 3'd4;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_PREP   = 4'b0010,
    ST_DABBLE = 4'b0100,
    ST_SCAN   = 4'b1000
  } srde_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // Capture a new input transaction.
    logic prep;       // Set up the conversion of the current radix.
    logic dabble;     // One double-dabble step.
    logic skip;       // Drop one leading zero digit.
    logic skip4;      // Drop four leading zero binary digits.
    logic emit;       // Send the top digit to the output register.
    logic next_kind;  // Advance to the next radix in the all mode.
  } srde_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic func_bad;     // Mode code has no meaning.
    logic kind_is_bcd;  // Current radix is decimal.
    logic dd_done;      // Last double-dabble step is in progress.
    logic skip_ok;      // Top digit is a leading zero that may be dropped.
    logic skip4_ok;     // Four leading binary zeros may be dropped at once.
    logic cnt_one;      // Only one digit position remains.
    logic out_free;     // Output register can take a digit this cycle.
    logic more_kinds;   // Another radix follows in the all mode.
  } srde_status_t;

endpackage

>>> hw/rtl/signed_radix_digit_emitter.sv
// Signed radix digit emitter.
//
// The input channel (in_valid_i / in_stall_o) takes a two's complement value
// and a mode: binary, octal, hex, BCD decimal, or all four in that order.
// Unused mode codes are consumed and produce nothing. The output channel
// (out_valid_o / out_stall_i) returns one digit per transaction, most
// significant first, with leading zeros dropped; a zero value gives one 0.
// Each digit carries its radix, the sign, an end-of-number flag and a flag
// on the last digit of the input transaction.
//
// One input transaction is worked on at a time. After the accept, each
// conversion runs a setup step; a BCD conversion then runs VALUE_WIDTH
// double-dabble steps. Leading zeros are then dropped one digit at a time
// (binary zeros four at a time where possible), and the digits are emitted.
// Reset empties the output register and returns the controller to idle.
// A stall on the output holds the current digit; the block then waits with
// the next digit, and takes a new input once its last digit is registered.
module signed_radix_digit_emitter #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic [2:0]             func_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [3:0]             digit_o,
  output logic [1:0]             radix_kind_o,
  output logic                   negative_o,
  output logic                   end_of_number_o,
  output logic                   last_o
);
  import srde_pkg::*;

  srde_cmd_t    cmd;
  srde_status_t status;
  logic         busy;

  // Sequencer.
  srde_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  // Digit datapath and output register.
  srde_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .value_i         (value_i),
    .func_i          (func_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .digit_o         (digit_o),
    .radix_kind_o    (radix_kind_o),
    .negative_o      (negative_o),
    .end_of_number_o (end_of_number_o),
    .last_o          (last_o)
  );

  assign in_stall_o = busy;

endmodule

>>> hw/rtl/srde_ctrl.sv
module srde_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  srde_pkg::srde_status_t status_i,
  output srde_pkg::srde_cmd_t   cmd_o,
  output logic                  busy_o
);
  import srde_pkg::*;

  srde_state_e state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PREP;
        end
      end
      ST_PREP: begin
        if (status_i.func_bad) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.prep = 1'b1;
          state_d    = status_i.kind_is_bcd ? ST_DABBLE : ST_SCAN;
        end
      end
      ST_DABBLE: begin
        cmd_o.dabble = 1'b1;
        if (status_i.dd_done) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.skip_ok) begin
          if (status_i.skip4_ok) begin
            cmd_o.skip4 = 1'b1;
          end else begin
            cmd_o.skip = 1'b1;
          end
        end else if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.cnt_one) begin
            if (status_i.more_kinds) begin
              cmd_o.next_kind = 1'b1;
              state_d         = ST_PREP;
            end else begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

>>> hw/rtl/srde_dp.sv
module srde_dp #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  srde_pkg::srde_cmd_t      cmd_i,
  output srde_pkg::srde_status_t   status_o,
  input  logic [VALUE_WIDTH-1:0]   value_i,
  input  logic [2:0]               func_i,
  input  logic                     out_stall_i,
  output logic                     out_valid_o,
  output logic [3:0]               digit_o,
  output logic [1:0]               radix_kind_o,
  output logic                     negative_o,
  output logic                     end_of_number_o,
  output logic                     last_o
);
  import srde_pkg::*;

  // Widths of the digit shifter and the decimal register.
  localparam int BCD_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int BW         = 4 * BCD_DIGITS;
  localparam int PW         = ((VALUE_WIDTH + 11) / 12) * 12;
  localparam int SW_RAW     = (PW > BW) ? PW : BW;
  localparam int SW         = ((SW_RAW + 11) / 12) * 12;
  localparam int CW         = $clog2(SW + 1);
  localparam int DW         = $clog2(VALUE_WIDTH + 1);

  localparam logic [CW-1:0] CNT_BIN = CW'(SW);
  localparam logic [CW-1:0] CNT_OCT = CW'(SW / 3);
  localparam logic [CW-1:0] CNT_HEX = CW'(SW / 4);
  localparam logic [CW-1:0] CNT_FOUR = CW'(4);
  localparam logic [DW-1:0] DD_STEPS = DW'(VALUE_WIDTH);

  logic [VALUE_WIDTH-1:0] mag_q, mag_d;
  logic                   neg_q, neg_d;
  logic [2:0]             func_q, func_d;
  logic                   all_q, all_d;
  logic [1:0]             kind_q, kind_d;
  logic [SW-1:0]          sh_q, sh_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic                   started_q, started_d;
  logic [VALUE_WIDTH-1:0] mq_q, mq_d;
  logic [BW-1:0]          bcd_q, bcd_d;
  logic [DW-1:0]          dd_cnt_q, dd_cnt_d;
  logic [BW-1:0]          bcd_adj;
  logic [3:0]             top_digit;
  logic [SW-1:0]          sh_step;
  logic [CW-1:0]          cnt_init;
  logic                   out_valid_q, out_valid_d;
  logic                   out_free;

  // Top digit of the shifter in the current radix.
  always_comb begin
    case (kind_q)
      KIND_BIN: top_digit = {3'b000, sh_q[SW-1]};
      KIND_OCT: top_digit = {1'b0, sh_q[SW-1 -: 3]};
      default:  top_digit = sh_q[SW-1 -: 4];
    endcase
  end

  // Shifter advanced by one digit, and the digit count for each radix.
  always_comb begin
    case (kind_q)
      KIND_BIN: begin
        sh_step  = {sh_q[SW-2:0], 1'b0};
        cnt_init = CNT_BIN;
      end
      KIND_OCT: begin
        sh_step  = {sh_q[SW-4:0], 3'b000};
        cnt_init = CNT_OCT;
      end
      default: begin
        sh_step  = {sh_q[SW-5:0], 4'b0000};
        cnt_init = CNT_HEX;
      end
    endcase
  end

  // Add-three correction on every decimal digit before the shift.
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // Status toward the controller.
  always_comb begin
    status_o.func_bad    = (func_q > FUNC_ALL);
    status_o.kind_is_bcd = (kind_q == KIND_BCD);
    status_o.dd_done     = (dd_cnt_q == DW'(1));
    status_o.cnt_one     = (cnt_q == CW'(1));
    status_o.skip_ok     = !started_q && (top_digit == 4'd0) && (cnt_q != CW'(1));
    status_o.skip4_ok    = (kind_q == KIND_BIN) && (sh_q[SW-1 -: 4] == 4'd0)
                           && (cnt_q > CNT_FOUR);
    status_o.out_free    = out_free;
    status_o.more_kinds  = all_q && (kind_q != KIND_BCD);
  end

  // Conversion registers.
  always_comb begin
    mag_d     = mag_q;
    neg_d     = neg_q;
    func_d    = func_q;
    all_d     = all_q;
    kind_d    = kind_q;
    sh_d      = sh_q;
    cnt_d     = cnt_q;
    started_d = started_q;
    mq_d      = mq_q;
    bcd_d     = bcd_q;
    dd_cnt_d  = dd_cnt_q;
    if (cmd_i.load) begin
      neg_d  = value_i[VALUE_WIDTH-1];
      mag_d  = value_i[VALUE_WIDTH-1] ? (~value_i + VALUE_WIDTH'(1)) : value_i;
      func_d = func_i;
      all_d  = (func_i == FUNC_ALL);
      kind_d = (func_i == FUNC_ALL) ? KIND_BIN : func_i[1:0];
    end
    if (cmd_i.prep) begin
      started_d = 1'b0;
      if (kind_q == KIND_BCD) begin
        mq_d     = mag_q;
        bcd_d    = '0;
        dd_cnt_d = DD_STEPS;
      end else begin
        sh_d  = SW'(mag_q);
        cnt_d = cnt_init;
      end
    end
    if (cmd_i.dabble) begin
      bcd_d    = {bcd_adj[BW-2:0], mq_q[VALUE_WIDTH-1]};
      mq_d     = {mq_q[VALUE_WIDTH-2:0], 1'b0};
      dd_cnt_d = dd_cnt_q - DW'(1);
      if (dd_cnt_q == DW'(1)) begin
        sh_d  = SW'({bcd_adj[BW-2:0], mq_q[VALUE_WIDTH-1]});
        cnt_d = CNT_HEX;
      end
    end
    if (cmd_i.skip4) begin
      sh_d  = {sh_q[SW-5:0], 4'b0000};
      cnt_d = cnt_q - CNT_FOUR;
    end
    if (cmd_i.skip || cmd_i.emit) begin
      sh_d  = sh_step;
      cnt_d = cnt_q - CW'(1);
    end
    if (cmd_i.emit) begin
      started_d = 1'b1;
    end
    if (cmd_i.next_kind) begin
      kind_d = kind_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q    <= mag_d;
    neg_q    <= neg_d;
    func_q   <= func_d;
    all_q    <= all_d;
    kind_q   <= kind_d;
    sh_q     <= sh_d;
    cnt_q    <= cnt_d;
    mq_q     <= mq_d;
    bcd_q    <= bcd_d;
    dd_cnt_q <= dd_cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
    end else begin
      started_q <= started_d;
    end
  end

  // Output register: holds a digit until the receiver takes it.
  always_comb begin
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      digit_o         <= top_digit;
      radix_kind_o    <= kind_q;
      negative_o      <= neg_q;
      end_of_number_o <= (cnt_q == CW'(1));
      last_o          <= (cnt_q == CW'(1)) && !(all_q && (kind_q != KIND_BCD));
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> hw/rtl/srde_checker.sv
module srde_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [3:0] digit_o,
  input logic [1:0] radix_kind_o,
  input logic       end_of_number_o,
  input logic       last_o
);
  import srde_pkg::*;

  // A stalled digit stays in place.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(digit_o)
      && $stable(radix_kind_o) && $stable(last_o))
    else $error("stalled output transaction changed");

  // Every digit lies within its radix.
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((radix_kind_o == KIND_BIN) && (digit_o <= 4'd1))
      || ((radix_kind_o == KIND_OCT) && (digit_o <= 4'd7))
      || (radix_kind_o == KIND_HEX)
      || ((radix_kind_o == KIND_BCD) && (digit_o <= 4'd9)))
    else $error("digit out of range for its radix");

  // The last digit of a transaction also closes its number.
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> end_of_number_o)
    else $error("last digit without end of number");

  // An accepted input keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted twice in a row");

endmodule

bind signed_radix_digit_emitter srde_checker u_srde_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .digit_o         (digit_o),
  .radix_kind_o    (radix_kind_o),
  .end_of_number_o (end_of_number_o),
  .last_o          (last_o)
);
